### rtl/core/stp_pkg.sv
// Package for the stick-to-paddle position block.
// Holds the configuration and command structures, register indexes and constants.
// Depends on nothing.
`default_nettype none

package stp_pkg;

   localparam logic [1:0] MODE_ABSOLUTE = 2'd0;
   localparam logic [1:0] MODE_RELATIVE = 2'd1;
   localparam logic [1:0] MODE_FOUR_WAY = 2'd2;

   localparam logic [2:0] REG_STICK_MODE    = 3'd0;
   localparam logic [2:0] REG_X_SCALE_MAX   = 3'd1;
   localparam logic [2:0] REG_Y_SCALE_MAX   = 3'd2;
   localparam logic [2:0] REG_WRAP_X_ENABLE = 3'd3;
   localparam logic [2:0] REG_WRAP_Y_ENABLE = 3'd4;
   localparam logic [2:0] REG_Y_AXIS_SELECT = 3'd5;

   localparam logic [1:0] RESET_STICK_MODE    = 2'd0;
   localparam logic [7:0] RESET_X_SCALE_MAX   = 8'd135;
   localparam logic [7:0] RESET_Y_SCALE_MAX   = 8'd160;
   localparam logic [1:0] RESET_Y_AXIS_SELECT = 2'd1;

   // Reciprocals ceil(2^24 / d) for the divisors 160, 80 and 53; exact for 16-bit dividends.
   localparam int unsigned RECIP_SHIFT = 24;
   localparam logic [18:0] RECIP_160   = 19'd104858;
   localparam logic [18:0] RECIP_80    = 19'd209716;
   localparam logic [18:0] RECIP_53    = 19'd316552;

   localparam logic [15:0] DEADZONE     = 16'd16384;
   localparam logic signed [15:0] POS_MAX     = 16'sd32767;
   localparam logic signed [15:0] POS_MIN     = -16'sd32768;
   localparam logic signed [15:0] SNAP_NEG    = -16'sd32767;
   localparam logic [16:0] SCALE_DIVISOR = 17'd65535;

   typedef struct packed {
      logic [1:0] stick_mode;
      logic [7:0] x_scale_max;
      logic [7:0] y_scale_max;
      logic       wrap_x_enable;
      logic       wrap_y_enable;
      logic [1:0] y_axis_select;
   } cfg_type;

   typedef struct packed {
      logic write_axis;
      logic load_tick;
      logic accel;
      logic position;
      logic scale;
      logic load_out;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCEL,
      ST_POSITION,
      ST_SCALE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

### rtl/core/stp_csr.sv
// Configuration registers of the stick-to-paddle block behind an APB-style port.
// Depends on stp_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module stp_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output      logic [31:0]      csr_prdata,
   output      logic             csr_pready,
   output      stp_pkg::cfg_type cfg
);

   stp_pkg::cfg_type cfg_ff;
   stp_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             write_en;

   assign index      = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            stp_pkg::REG_STICK_MODE:    cfg_in.stick_mode    = csr_pwdata[1:0];
            stp_pkg::REG_X_SCALE_MAX:   cfg_in.x_scale_max   = csr_pwdata[7:0];
            stp_pkg::REG_Y_SCALE_MAX:   cfg_in.y_scale_max   = csr_pwdata[7:0];
            stp_pkg::REG_WRAP_X_ENABLE: cfg_in.wrap_x_enable = csr_pwdata[0];
            stp_pkg::REG_WRAP_Y_ENABLE: cfg_in.wrap_y_enable = csr_pwdata[0];
            stp_pkg::REG_Y_AXIS_SELECT: cfg_in.y_axis_select = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_mode    <= stp_pkg::RESET_STICK_MODE;
         cfg_ff.x_scale_max   <= stp_pkg::RESET_X_SCALE_MAX;
         cfg_ff.y_scale_max   <= stp_pkg::RESET_Y_SCALE_MAX;
         cfg_ff.wrap_x_enable <= 1'b0;
         cfg_ff.wrap_y_enable <= 1'b0;
         cfg_ff.y_axis_select <= stp_pkg::RESET_Y_AXIS_SELECT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         stp_pkg::REG_STICK_MODE:    csr_prdata = {30'd0, cfg_ff.stick_mode};
         stp_pkg::REG_X_SCALE_MAX:   csr_prdata = {24'd0, cfg_ff.x_scale_max};
         stp_pkg::REG_Y_SCALE_MAX:   csr_prdata = {24'd0, cfg_ff.y_scale_max};
         stp_pkg::REG_WRAP_X_ENABLE: csr_prdata = {31'd0, cfg_ff.wrap_x_enable};
         stp_pkg::REG_WRAP_Y_ENABLE: csr_prdata = {31'd0, cfg_ff.wrap_y_enable};
         stp_pkg::REG_Y_AXIS_SELECT: csr_prdata = {30'd0, cfg_ff.y_axis_select};
         default:                    csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/stp_ctrl.sv
// Controller state machine of the stick-to-paddle block: handshakes and datapath commands.
// Depends on stp_pkg for state_type and cmd_type.
`default_nettype none

module stp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_action,
   output      logic             req_tready,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      stp_pkg::cmd_type cmd
);

   stp_pkg::state_type state_ff;
   stp_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stp_pkg::ST_IDLE: begin
            if (req_tvalid && req_action) begin
               state_in = stp_pkg::ST_ACCEL;
            end
         end
         stp_pkg::ST_ACCEL:    state_in = stp_pkg::ST_POSITION;
         stp_pkg::ST_POSITION: state_in = stp_pkg::ST_SCALE;
         stp_pkg::ST_SCALE:    state_in = stp_pkg::ST_EMIT;
         stp_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = stp_pkg::ST_IDLE;
            end
         end
         default: state_in = stp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         stp_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.write_axis = req_tvalid & ~req_action;
            cmd.load_tick  = req_tvalid & req_action;
         end
         stp_pkg::ST_ACCEL:    cmd.accel    = 1'b1;
         stp_pkg::ST_POSITION: cmd.position = 1'b1;
         stp_pkg::ST_SCALE:    cmd.scale    = 1'b1;
         stp_pkg::ST_EMIT:     cmd.load_out = ~rsp_valid_ff | rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/stp_datapath.sv
// Datapath of the stick-to-paddle block: axis store, acceleration, position and scaling.
// Depends on stp_pkg for cfg_type, cmd_type and the arithmetic constants.
`default_nettype none

module stp_datapath #(
   parameter int AXIS_COUNT = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stp_pkg::cfg_type   cfg,
   input  wire stp_pkg::cmd_type   cmd,
   input  wire logic [2:0]         axis_number,
   input  wire logic signed [15:0] axis_value,
   output      logic [47:0]        rsp_data
);

   localparam int IDX_W = $clog2(AXIS_COUNT);

   logic signed [15:0] store_ff [AXIS_COUNT];
   logic signed [15:0] x_ff, y_ff;
   logic signed [15:0] pos_x_ff, pos_y_ff;
   logic signed [15:0] pos_x_in, pos_y_in;
   logic [34:0]        prod_x_ff, prod_y_ff;
   logic [23:0]        scale_x_ff, scale_y_ff;
   logic [47:0]        rsp_data_ff;

   logic [4:0]         num_ext;
   logic               num_ok;
   logic [IDX_W-1:0]   wr_idx;
   logic [4:0]         ysel_ext;
   logic [IDX_W-1:0]   ysel_idx;
   logic [15:0]        mag_x, mag_y;
   logic [7:0]         paddle_x, paddle_y;

   assign num_ext  = {2'b00, axis_number};
   assign num_ok   = num_ext < 5'(AXIS_COUNT);
   assign wr_idx   = num_ext[IDX_W-1:0];
   assign ysel_ext = {3'b000, cfg.y_axis_select};
   assign ysel_idx = ysel_ext[IDX_W-1:0];

   function automatic logic [15:0] magnitude(input logic signed [15:0] v);
      logic [15:0] r;
      r = v[15] ? 16'(-v) : 16'(v);
      return r;
   endfunction

   // |v| / 16384 picks the divisor 160, 80 or 53.
   function automatic logic [18:0] recip(input logic [15:0] m);
      logic [18:0] r;
      case (m[15:14])
         2'b00:   r = stp_pkg::RECIP_160;
         2'b01:   r = stp_pkg::RECIP_80;
         default: r = stp_pkg::RECIP_53;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] move(input logic signed [15:0] p,
                                               input logic [34:0]        prod,
                                               input logic               neg,
                                               input logic               wrap);
      logic [10:0]        q;
      logic signed [17:0] a;
      logic signed [17:0] s;
      logic signed [15:0] r;
      q = prod[34:stp_pkg::RECIP_SHIFT];
      a = neg ? -18'sd0 - 18'($signed({1'b0, q})) : 18'($signed({1'b0, q}));
      s = 18'(p) + a;
      if (s < 18'(stp_pkg::POS_MIN)) begin
         r = wrap ? s[15:0] : stp_pkg::POS_MIN;
      end else if (s > 18'(stp_pkg::POS_MAX)) begin
         r = wrap ? s[15:0] : stp_pkg::POS_MAX;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

   // Division by 65535: quotient from the upper bits, then one correction step.
   function automatic logic [7:0] div_full(input logic [23:0] t);
      logic [7:0]  q;
      logic [16:0] rem;
      q   = t[23:16];
      rem = {1'b0, t[15:0]} + {9'd0, q};
      return (rem >= stp_pkg::SCALE_DIVISOR) ? q + 8'd1 : q;
   endfunction

   assign mag_x = magnitude(x_ff);
   assign mag_y = magnitude(y_ff);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      case (cfg.stick_mode)
         stp_pkg::MODE_RELATIVE: begin
            pos_x_in = move(pos_x_ff, prod_x_ff, x_ff[15], cfg.wrap_x_enable);
            pos_y_in = move(pos_y_ff, prod_y_ff, y_ff[15], cfg.wrap_y_enable);
         end
         stp_pkg::MODE_FOUR_WAY: begin
            if (mag_x > stp_pkg::DEADZONE) begin
               if (mag_x > mag_y) begin
                  pos_x_in = x_ff[15] ? stp_pkg::SNAP_NEG : stp_pkg::POS_MAX;
                  pos_y_in = 16'sd0;
               end else if (mag_y > mag_x) begin
                  pos_x_in = 16'sd0;
                  pos_y_in = y_ff[15] ? stp_pkg::SNAP_NEG : stp_pkg::POS_MAX;
               end
            end else if (mag_y > stp_pkg::DEADZONE) begin
               pos_x_in = 16'sd0;
               pos_y_in = y_ff[15] ? stp_pkg::SNAP_NEG : stp_pkg::POS_MAX;
            end else begin
               pos_x_in = 16'sd0;
               pos_y_in = 16'sd0;
            end
         end
         default: begin
            pos_x_in = x_ff;
            pos_y_in = y_ff;
         end
      endcase
   end

   assign paddle_x = div_full(scale_x_ff);
   assign paddle_y = div_full(scale_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            store_ff[i] <= 16'sd0;
         end
         pos_x_ff <= 16'sd0;
         pos_y_ff <= 16'sd0;
      end else begin
         if (cmd.write_axis && num_ok) begin
            store_ff[wr_idx] <= axis_value;
         end
         if (cmd.position) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tick) begin
         x_ff <= store_ff[0];
         y_ff <= store_ff[ysel_idx];
      end
      if (cmd.accel) begin
         prod_x_ff <= 35'(mag_x * recip(mag_x));
         prod_y_ff <= 35'(mag_y * recip(mag_y));
      end
      if (cmd.scale) begin
         scale_x_ff <= 24'({~pos_x_ff[15], pos_x_ff[14:0]} * cfg.x_scale_max);
         scale_y_ff <= 24'({~pos_y_ff[15], pos_y_ff[14:0]} * cfg.y_scale_max);
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {pos_y_ff, pos_x_ff, paddle_y, paddle_x};
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/core/stick_to_paddle_position.sv
// Top level of the stick-to-paddle position block; joins registers, controller and datapath.
// An update beat is taken while idle and the next beat may follow at once. A tick beat gives
// its result after the four steps of the controller (acceleration multiply, position,
// scaling multiply, output load), and no new beat is taken until the load is done. The output
// register holds a result while the next beat is taken.
// Synchronous reset clears the axis store and positions and loads the register defaults.
`default_nettype none

module stick_to_paddle_position #(
   parameter int AXIS_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,   // axis_number[2:0], axis_value[18:3], zero fill
   input  wire logic        req_tuser,   // action[0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // x_paddle, y_paddle, x_position, y_position
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   stp_pkg::cfg_type cfg;
   stp_pkg::cmd_type cmd;

   stp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   stp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   stp_datapath #(
      .AXIS_COUNT (AXIS_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .axis_number (req_tdata[2:0]),
      .axis_value  ($signed(req_tdata[18:3])),
      .rsp_data    (rsp_tdata)
   );

endmodule

`default_nettype wire

### tb/sv/stick_to_paddle_position_tb.sv
// Self-checking testbench for the stick-to-paddle position block.
// Drives axis update and tick beats and APB register writes, predicts each result in
// SystemVerilog or takes it from the script, and compares it field by field. Depends on stp_pkg and the block's RTL.
`timescale 1ns / 100ps

module stick_to_paddle_position_tb;

   localparam logic [2:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [2:0] REG_SPARE_HIGH = 3'd7;
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int SETTLE_CYCLES  = 8;
   localparam int QUIET_LIMIT    = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_BEATS    = 83;

   typedef struct packed {
      logic              action;
      logic [2:0]        axis_number;
      logic signed [15:0] axis_value;
   } stick_beat_type;

   typedef struct packed {
      logic [7:0]         x_paddle;
      logic [7:0]         y_paddle;
      logic signed [15:0] x_position;
      logic signed [15:0] y_position;
   } paddle_type;

   typedef struct {
      bit             is_csr;
      logic [2:0]     reg_idx;
      logic [31:0]    reg_val;
      stick_beat_type beat;
      bit             typed;
      paddle_type     want;
   } script_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state and configuration copy.
   logic signed [15:0] axis_mirror [8];
   int                 pos_x, pos_y;
   logic [1:0]         cfg_mode;
   logic [7:0]         cfg_x_max, cfg_y_max;
   logic               cfg_wrap_x, cfg_wrap_y;
   logic [1:0]         cfg_sel;

   paddle_type     paddle_expect [$];
   script_row_type script [$];
   int  faults = 0;
   int  tick_count = 0, update_count = 0, result_count = 0, csr_count = 0;
   int  quiet = 0;
   bit  idle_on = 1'b1;
   bit  hold_rsp_req = 1'b0;

   stick_to_paddle_position dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int accel_step(input int v);
      int den;
      den = 160 / (1 + ((v < 0) ? -v : v) / 16384);
      return v / den;
   endfunction

   function automatic int advance(input int p, input int v, input bit wrap);
      int s;
      s = p + accel_step(v);
      if (s < -32768) s = wrap ? s + 65536 : -32768;
      if (s > 32767) s = wrap ? s - 65536 : 32767;
      return s;
   endfunction

   function automatic logic [7:0] to_paddle(input int p, input logic [7:0] span);
      longint u;
      u = longint'(p) + 32768;
      return 8'((u * longint'(span)) / 65535);
   endfunction

   function automatic void cfg_apply(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
         stp_pkg::REG_STICK_MODE:    cfg_mode   = v[1:0];
         stp_pkg::REG_X_SCALE_MAX:   cfg_x_max  = v[7:0];
         stp_pkg::REG_Y_SCALE_MAX:   cfg_y_max  = v[7:0];
         stp_pkg::REG_WRAP_X_ENABLE: cfg_wrap_x = v[0];
         stp_pkg::REG_WRAP_Y_ENABLE: cfg_wrap_y = v[0];
         stp_pkg::REG_Y_AXIS_SELECT: cfg_sel    = v[1:0];
         default: ;
      endcase
   endfunction

   function automatic void paddle_step(input stick_beat_type b, output bit has,
                                       output paddle_type r);
      int x, y, ax, ay;
      has = 1'b0;
      r = '0;
      if (!b.action) begin
         axis_mirror[b.axis_number] = b.axis_value;
         return;
      end
      x = axis_mirror[0];
      y = axis_mirror[cfg_sel];
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (cfg_mode == stp_pkg::MODE_RELATIVE) begin
         pos_x = advance(pos_x, x, cfg_wrap_x);
         pos_y = advance(pos_y, y, cfg_wrap_y);
      end else if (cfg_mode == stp_pkg::MODE_FOUR_WAY) begin
         if (ax > 16384) begin
            if (ax > ay) begin
               pos_x = (x > 0) ? 32767 : -32767;
               pos_y = 0;
            end else if (ay > ax) begin
               pos_x = 0;
               pos_y = (y > 0) ? 32767 : -32767;
            end
         end else if (ay > 16384) begin
            pos_x = 0;
            pos_y = (y > 0) ? 32767 : -32767;
         end else begin
            pos_x = 0;
            pos_y = 0;
         end
      end else begin
         pos_x = x;
         pos_y = y;
      end
      has = 1'b1;
      r.x_paddle   = to_paddle(pos_x, cfg_x_max);
      r.y_paddle   = to_paddle(pos_y, cfg_y_max);
      r.x_position = 16'(pos_x);
      r.y_position = 16'(pos_y);
   endfunction

   function automatic void log_beat(input stick_beat_type b, input bit typed,
                                    input paddle_type want);
      bit         has;
      paddle_type r;
      paddle_step(b, has, r);
      if (b.action) tick_count++;
      else update_count++;
      if (has) paddle_expect.push_back(typed ? want : r);
   endfunction

   function automatic stick_beat_type make_beat(input bit act, input int num,
                                                input logic signed [15:0] v);
      stick_beat_type b;
      b.action      = act;
      b.axis_number = 3'(num);
      b.axis_value  = v;
      return b;
   endfunction

   function automatic logic signed [15:0] pick_reading();
      case ($urandom_range(9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         3: return $urandom_range(1) ? 16'sd16385 : -16'sd16385;
         4: return 16'sd0;
         5: return 16'($signed($urandom_range(400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic script_row_type row_update(input int num, input int v);
      script_row_type row;
      row = '{default: '0};
      row.beat = make_beat(1'b0, num, 16'(v));
      return row;
   endfunction

   function automatic script_row_type row_tick();
      script_row_type row;
      row = '{default: '0};
      row.beat = make_beat(1'b1, 0, 16'sd0);
      return row;
   endfunction

   function automatic script_row_type row_tick_is(input int xp, input int yp, input int xs,
                                                  input int ys);
      script_row_type row;
      row = row_tick();
      row.typed = 1'b1;
      row.want  = '{x_paddle: 8'(xp), y_paddle: 8'(yp), x_position: 16'(xs),
                    y_position: 16'(ys)};
      return row;
   endfunction

   function automatic script_row_type row_csr(input logic [2:0] idx, input logic [31:0] v);
      script_row_type row;
      row = '{default: '0};
      row.is_csr  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = v;
      return row;
   endfunction

   task automatic send_beat(input stick_beat_type b);
      if (idle_on && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, b.axis_value, b.axis_number};
      req_tuser  <= b.action;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (paddle_expect.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] v);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_apply(idx, v);
      csr_count++;
   endtask

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin
      paddle_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got.x_paddle   = rsp_tdata[7:0];
         got.y_paddle   = rsp_tdata[15:8];
         got.x_position = rsp_tdata[31:16];
         got.y_position = rsp_tdata[47:32];
         if (paddle_expect.size() == 0) begin
            $error("result beat with no expected result waiting");
            faults++;
         end else begin
            want = paddle_expect.pop_front();
            result_count++;
            if (got.x_paddle !== want.x_paddle) begin
               $error("x_paddle expected %0d, got %0d", want.x_paddle, got.x_paddle);
               faults++;
            end
            if (got.y_paddle !== want.y_paddle) begin
               $error("y_paddle expected %0d, got %0d", want.y_paddle, got.y_paddle);
               faults++;
            end
            if (got.x_position !== want.x_position) begin
               $error("x_position expected %0d, got %0d", want.x_position, got.x_position);
               faults++;
            end
            if (got.y_position !== want.y_position) begin
               $error("y_position expected %0d, got %0d", want.y_position, got.y_position);
               faults++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
         $display("stick_to_paddle_position: mismatch");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int             p, k, r, num;
      logic signed [15:0] v;
      stick_beat_type b;
      paddle_type     none;

      none = '0;
      foreach (axis_mirror[i]) axis_mirror[i] = '0;
      pos_x = 0;
      pos_y = 0;
      cfg_mode   = stp_pkg::RESET_STICK_MODE;
      cfg_x_max  = stp_pkg::RESET_X_SCALE_MAX;
      cfg_y_max  = stp_pkg::RESET_Y_SCALE_MAX;
      cfg_wrap_x = 1'b0;
      cfg_wrap_y = 1'b0;
      cfg_sel    = stp_pkg::RESET_Y_AXIS_SELECT;

      script.push_back(row_tick_is(67, 80, 0, 0));
      script.push_back(row_update(0, 32767));
      script.push_back(row_update(1, -32768));
      script.push_back(row_tick_is(135, 0, 32767, -32768));
      script.push_back(row_csr(stp_pkg::REG_X_SCALE_MAX, 32'd0));
      script.push_back(row_csr(stp_pkg::REG_Y_SCALE_MAX, 32'd255));
      script.push_back(row_update(1, 32767));
      script.push_back(row_tick_is(0, 255, 32767, 32767));
      script.push_back(row_csr(stp_pkg::REG_STICK_MODE, 32'(MODE_SPARE)));
      script.push_back(row_update(7, -1));
      script.push_back(row_csr(stp_pkg::REG_Y_AXIS_SELECT, 32'd0));
      script.push_back(row_tick());
      script.push_back(row_csr(stp_pkg::REG_Y_AXIS_SELECT, 32'd2));
      script.push_back(row_update(2, -32768));
      script.push_back(row_tick());
      script.push_back(row_csr(stp_pkg::REG_X_SCALE_MAX, 32'(stp_pkg::RESET_X_SCALE_MAX)));
      script.push_back(row_csr(stp_pkg::REG_Y_SCALE_MAX, 32'(stp_pkg::RESET_Y_SCALE_MAX)));
      script.push_back(row_csr(stp_pkg::REG_STICK_MODE, 32'(stp_pkg::MODE_RELATIVE)));
      script.push_back(row_csr(stp_pkg::REG_WRAP_X_ENABLE, 32'd1));
      script.push_back(row_tick());
      script.push_back(row_csr(stp_pkg::REG_WRAP_X_ENABLE, 32'd0));
      script.push_back(row_csr(stp_pkg::REG_WRAP_Y_ENABLE, 32'd1));
      script.push_back(row_tick());
      script.push_back(row_csr(stp_pkg::REG_STICK_MODE, 32'(stp_pkg::MODE_FOUR_WAY)));
      script.push_back(row_update(0, -20000));
      script.push_back(row_update(2, 20000));
      script.push_back(row_tick());
      script.push_back(row_update(2, -100));
      script.push_back(row_tick());
      script.push_back(row_update(0, 16384));
      script.push_back(row_tick());
      script.push_back(row_update(2, -16385));
      script.push_back(row_tick());
      script.push_back(row_csr(REG_SPARE_LOW, 32'hFFFF_FFFF));
      script.push_back(row_csr(REG_SPARE_HIGH, 32'd0));
      script.push_back(row_csr(stp_pkg::REG_Y_AXIS_SELECT, 32'd3));
      script.push_back(row_update(3, 16385));
      script.push_back(row_tick());

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            write_csr(script[i].reg_idx, script[i].reg_val);
         end else begin
            send_beat(script[i].beat);
            log_beat(script[i].beat, script[i].typed, script[i].want);
         end
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         idle_on = (p != 3);
         write_csr(stp_pkg::REG_STICK_MODE, ($urandom & 32'hFFFF_FF00) | 32'(p % 4));
         write_csr(stp_pkg::REG_X_SCALE_MAX, (p == 1) ? 32'd0
                                             : (p == 2 || p == 5) ? 32'd255
                                             : 32'($urandom_range(255)));
         write_csr(stp_pkg::REG_Y_SCALE_MAX, (p == 2) ? 32'd0
                                             : (p == 1 || p == 6) ? 32'd255
                                             : 32'($urandom_range(255)));
         write_csr(stp_pkg::REG_WRAP_X_ENABLE,
                   ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(1)));
         write_csr(stp_pkg::REG_WRAP_Y_ENABLE,
                   ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(1)));
         write_csr(stp_pkg::REG_Y_AXIS_SELECT,
                   ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(3)));
         for (k = 0; k < PHASE_BEATS; k++) begin
            if (p == 5 && k == 10) hold_rsp_req = 1'b1;
            if (p == 6 && k == 40) drain_results();
            r = $urandom_range(99);
            if (r < 40) begin
               b = make_beat(1'b1, $urandom_range(7), 16'($urandom));
            end else if (r < 60) begin
               b = make_beat(1'b0, 0, pick_reading());
            end else if (r < 80) begin
               // A quarter of these copy the X magnitude so that four-way ties occur.
               if ($urandom_range(3) == 0) v = $urandom_range(1) ? axis_mirror[0]
                                                                 : -axis_mirror[0];
               else v = pick_reading();
               b = make_beat(1'b0, cfg_sel, v);
            end else begin
               num = $urandom_range(7);
               b = make_beat(1'b0, num, 16'($urandom));
            end
            send_beat(b);
            log_beat(b, 1'b0, none);
         end
      end

      idle_on = 1'b1;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (paddle_expect.size() != 0) begin
         $error("%0d expected results never arrived", paddle_expect.size());
         faults++;
      end
      $display("Covered %0d ticks and %0d axis updates across %0d register writes,",
               tick_count, update_count, csr_count);
      $display("with all four stick modes, both wrap settings and scale limits 0 and 255.");
      if (faults == 0) begin
         $display("stick_to_paddle_position: match");
      end else begin
         $display("stick_to_paddle_position: mismatch");
      end
      $finish;
   end

endmodule
